[rtl/core/min_or_partition_search_unit_macros.svh]
// Assertion macros shared by the checker of the minimum-OR partition search unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MIN_OR_PARTITION_SEARCH_UNIT_MACROS_SVH
`define MIN_OR_PARTITION_SEARCH_UNIT_MACROS_SVH

// Implication into the next cycle, masked while reset is high.
`define MOPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Implication into the next cycle, also checked through reset.
`define MOPS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/core/mops_pkg.sv]
// Shared types and constants for the minimum-OR partition search unit.
// No dependencies; imported by the top level and the checker.
package mops_pkg;

   // result width, bit counter width and port field widths
   localparam int RES_BITS   = 40;
   localparam int BIT_IDX_W  = 6;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 32;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_GROUPS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_GROUPS = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

[rtl/core/mops_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the prefix-sum and reachability stores.
module mops_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/core/min_or_partition_search_unit.sv]
// Minimum-OR partition search unit: top level.
// Depends on mops_pkg and mops_ram.
//
// Values stream in one beat per cycle and are kept as running prefix sums in a RAM.
// The beat with tlast starts the search over the n stored values (later values past
// MAX_ITEMS are dropped). The answer is settled from bit 39 down: for each bit a
// reachability row over segment counts is built for every prefix j, reading rows
// t < j one per cycle from the reachability RAM, which has one read port. After the
// trial for bit 0 the result beat is offered on rsp_. No input beat is taken during
// a search. An infeasible group range gives all ones.
module min_or_partition_search_unit
   import mops_pkg::*;
#(
   parameter int MAX_ITEMS  = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic                  req_tlast,   // last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RES_BITS-1:0]   rsp_tdata,   // [39:0] min_or
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = $clog2(MAX_ITEMS + 1);
   localparam int ROWW  = MAX_ITEMS + 1;
   localparam int SUMW  = VALUE_BITS + $clog2(MAX_ITEMS);
   localparam int EXTW  = SUMW + RES_BITS;
   localparam int KW    = (AW > CSR_DATA_W) ? AW : CSR_DATA_W;

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] min_groups_ff, max_groups_ff;
   logic [AW-1:0]         count_ff, count_in;
   logic [AW-1:0]         n_ff, n_in;
   logic [AW-1:0]         j_ff, j_in;
   logic [AW-1:0]         t_ff, t_in;
   logic [BIT_IDX_W-1:0]  bit_ff, bit_in;
   logic [RES_BITS-1:0]   ans_ff, ans_in;
   logic [SUMW-1:0]       sum_ff, sum_in;
   logic [SUMW-1:0]       pj_ff, pj_in;
   logic [ROWW-1:0]       acc_ff, acc_in;
   logic [ROWW-1:0]       mask_ff, mask_in;
   logic                  vld_d_ff, vld_d_in;
   logic                  first_d_ff, first_d_in;
   logic                  zero_d_ff, zero_d_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RES_BITS-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic                  req_beat;
   logic [VALUE_BITS+REQ_DATA_W-1:0] value_ext;
   logic [VALUE_BITS-1:0] value_kept;
   logic [SUMW-1:0]       sum_new;
   logic                  pre_wr_en;
   logic [SUMW-1:0]       pre_rd;
   logic [ROWW-1:0]       reach_rd;
   logic                  reach_wr_en;
   logic [SUMW-1:0]       pt;
   logic [SUMW-1:0]       seg_sum;
   logic [RES_BITS-1:0]   allow;
   logic                  seg_fits;
   logic [ROWW-1:0]       row_t;
   logic                  trial_fits;
   logic [KW-1:0]         lo_ext, hi_ext;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // keep the low VALUE_BITS of the 32-bit field
   assign value_ext  = {{VALUE_BITS{1'b0}}, req_tdata};
   assign value_kept = value_ext[VALUE_BITS-1:0];
   assign sum_new    = ((count_ff == '0) ? '0 : sum_ff) + SUMW'(value_kept);
   assign pre_wr_en  = req_beat && (count_ff < AW'(MAX_ITEMS));

   // prefix sums: entry i holds the sum of the first i values; entry 0 is read but its data is never used
   mops_ram #(.WIDTH(SUMW), .DEPTH(MAX_ITEMS + 1)) u_prefix_ram (
      .clock   (clock),
      .wr_en   (pre_wr_en),
      .wr_addr (count_ff + AW'(1)),
      .wr_data (sum_new),
      .rd_addr (t_ff),
      .rd_data (pre_rd)
   );

   // reachability rows: bit k of row j set when j values split into k segments
   mops_ram #(.WIDTH(ROWW), .DEPTH(MAX_ITEMS + 1)) u_reach_ram (
      .clock   (clock),
      .wr_en   (reach_wr_en),
      .wr_addr (j_ff),
      .wr_data (acc_in),
      .rd_addr (t_ff),
      .rd_data (reach_rd)
   );

   // segment check for the beat returning from the RAMs
   assign pt       = zero_d_ff ? '0 : pre_rd;
   assign seg_sum  = pj_ff - pt;
   assign allow    = ans_ff | ((RES_BITS'(1) << bit_ff) - RES_BITS'(1));
   assign seg_fits = ((EXTW'(seg_sum) & ~EXTW'(allow)) == '0);
   assign row_t    = zero_d_ff ? ROWW'(1) : reach_rd;

   // final row against the allowed count range
   assign trial_fits = |(acc_ff & mask_ff);
   assign lo_ext     = KW'(min_groups_ff);
   assign hi_ext     = KW'(max_groups_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:  if (req_beat && req_tlast) state_in = ST_SCAN;
         ST_SCAN:  if (t_ff == '0) state_in = ST_DRAIN;
         ST_DRAIN: state_in = (j_ff == n_ff) ? ST_CHECK : ST_SCAN;
         ST_CHECK: state_in = (bit_ff == '0) ? ST_DONE : ST_SCAN;
         ST_DONE:  if (!rsp_tvalid_ff || rsp_tready) state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      n_in          = n_ff;
      j_in          = j_ff;
      t_in          = t_ff;
      bit_in        = bit_ff;
      ans_in        = ans_ff;
      sum_in        = sum_ff;
      pj_in         = pj_ff;
      acc_in        = acc_ff;
      mask_in       = mask_ff;
      vld_d_in      = 1'b0;
      first_d_in    = 1'b0;
      zero_d_in     = 1'b0;
      reach_wr_en   = 1'b0;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      // returning read beat: first beat latches prefix j, others fold row t
      if (vld_d_ff) begin
         if (first_d_ff) begin
            pj_in  = pre_rd;
            acc_in = '0;
         end else if (seg_fits) begin
            acc_in = acc_ff | (row_t << 1);
         end
      end

      unique case (state_ff)
         ST_LOAD: begin
            for (int k = 0; k < ROWW; k++) begin
               mask_in[k] = (KW'(k) >= lo_ext) && (KW'(k) <= hi_ext);
            end
            if (req_beat) begin
               if (pre_wr_en) begin
                  sum_in   = sum_new;
                  count_in = count_ff + AW'(1);
               end
               if (req_tlast) begin
                  n_in     = pre_wr_en ? (count_ff + AW'(1)) : count_ff;
                  count_in = '0;
                  j_in     = AW'(1);
                  t_in     = AW'(1);
                  bit_in   = BIT_IDX_W'(RES_BITS - 1);
                  ans_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            vld_d_in   = 1'b1;
            first_d_in = (t_ff == j_ff);
            zero_d_in  = (t_ff == '0);
            if (t_ff != '0) t_in = t_ff - AW'(1);
         end
         ST_DRAIN: begin
            reach_wr_en = 1'b1;
            if (j_ff != n_ff) begin
               j_in = j_ff + AW'(1);
               t_in = j_ff + AW'(1);
            end
         end
         ST_CHECK: begin
            if (!trial_fits) ans_in = ans_ff | (RES_BITS'(1) << bit_ff);
            if (bit_ff != '0) begin
               bit_in = bit_ff - BIT_IDX_W'(1);
               j_in   = AW'(1);
               t_in   = AW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in  = ans_ff;
               rsp_tvalid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         vld_d_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         min_groups_ff <= CSR_DATA_W'(1);
         max_groups_ff <= CSR_DATA_W'(1);
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         vld_d_ff      <= vld_d_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_MIN_GROUPS: min_groups_ff <= csr_wdata;
               REG_MAX_GROUPS: max_groups_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      j_ff         <= j_in;
      t_ff         <= t_in;
      bit_ff       <= bit_in;
      ans_ff       <= ans_in;
      sum_ff       <= sum_in;
      pj_ff        <= pj_in;
      acc_ff       <= acc_in;
      mask_ff      <= mask_in;
      first_d_ff   <= first_d_in;
      zero_d_ff    <= zero_d_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

[rtl/core/mops_checker.sv]
// Port-level checks for the minimum-OR partition search unit, bound to the top level.
// Depends on mops_pkg and min_or_partition_search_unit_macros.svh.
`include "min_or_partition_search_unit_macros.svh"

module mops_checker
   import mops_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                req_tlast,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RES_BITS-1:0] rsp_tdata
);

   // a last beat starts the search, so intake closes at once
   `MOPS_ASSERT_NEXT(a_last_closes, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)
   // ordinary beats keep intake open
   `MOPS_ASSERT_NEXT(a_load_open, clock, reset, req_tvalid && req_tready && !req_tlast, req_tready)
   // a stalled result beat holds its data
   `MOPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // no result right after reset
   `MOPS_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_tvalid)

endmodule

bind min_or_partition_search_unit mops_checker u_mops_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[dv/tb_top.sv]
// Testbench for the minimum-OR partition search unit: stream stimulus, a predictor
// and a scoreboard. Depends on mops_pkg and the min_or_partition_search_unit RTL.
`timescale 1ns / 100ps

module tb_top;
   import mops_pkg::*;

   localparam int MAX_N      = 256;
   localparam int RAND_ITEMS = 1750;

   // Predicts the minimum OR of segment sums and keeps the expected results.
   class min_or_scoreboard;
      logic [31:0] seq_values[$];
      logic [RES_BITS-1:0] min_or_queue[$];
      int unsigned min_groups = 1;
      int unsigned max_groups = 1;
      int errors = 0;
      int results_seen = 0;

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == REG_MIN_GROUPS) min_groups = 32'(val);
         else max_groups = 32'(val);
      endfunction

      // any partition of n items into lo..hi segments with all sums inside allow?
      function bit partition_fits(int n, logic [63:0] allow);
         bit [MAX_N:0] reach[0:MAX_N];
         logic [63:0] psum[0:MAX_N];
         logic [63:0] seg;
         int hi;
         psum[0] = 0;
         for (int i = 0; i < n; i++) psum[i+1] = psum[i] + seq_values[i];
         for (int j = 0; j <= n; j++) reach[j] = '0;
         reach[0][0] = 1'b1;
         for (int j = 1; j <= n; j++)
            for (int t = 0; t < j; t++) begin
               seg = psum[j] - psum[t];
               if ((seg | allow) == allow) reach[j] |= reach[t] << 1;
            end
         hi = (max_groups > n) ? n : max_groups;
         for (int k = min_groups; k <= hi; k++)
            if (reach[n][k]) return 1'b1;
         return 1'b0;
      endfunction

      // accepted request beat
      function void note_beat(logic [31:0] value, logic last);
         logic [63:0] answer;
         logic [63:0] allow;
         if (seq_values.size() < MAX_N) seq_values.push_back(value);
         if (!last) return;
         answer = 0;
         for (int b = RES_BITS - 1; b >= 0; b--) begin
            allow = answer | ((64'd1 << b) - 1);
            if (!partition_fits(seq_values.size(), allow)) answer |= 64'd1 << b;
         end
         min_or_queue.push_back(answer[RES_BITS-1:0]);
         seq_values.delete();
      endfunction

      // accepted response beat
      function void check_result(logic [RES_BITS-1:0] actual);
         logic [RES_BITS-1:0] expected;
         results_seen++;
         if (min_or_queue.size() == 0) begin
            $error("unexpected result beat, min_or %h", actual);
            errors++;
            return;
         end
         expected = min_or_queue.pop_front();
         if (actual !== expected) begin
            $error("min_or mismatch: expected %h, actual %h", expected, actual);
            errors++;
         end
      endfunction

      function int pending();
         return min_or_queue.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RES_BITS-1:0]   rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   min_or_scoreboard sb = new();
   int  beats_sent = 0;
   int  searches = 0;
   bit  rsp_steady = 1'b0;

   always #10 clock = ~clock;

   min_or_partition_search_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side stalls
   always @(posedge clock) begin
      if (rsp_steady) rsp_tready <= 1'b1;
      else rsp_tready <= (pick_gap() == 0);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_beat(logic [31:0] value, logic last, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_beat(value, last);
      beats_sent++;
      if (last) searches++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic set_groups(int lo, int hi);
      wait_idle();
      csr_write(REG_MIN_GROUPS, CSR_DATA_W'(lo));
      csr_write(REG_MAX_GROUPS, CSR_DATA_W'(hi));
      csr_wr_en <= 1'b0;
   endtask

   // one sequence of n values; style picks the value distribution
   task automatic send_sequence(int n, int style);
      logic [31:0] v;
      for (int i = 0; i < n; i++) begin
         case (style)
            0: v = $urandom_range(0, 15);
            1: v = 32'd1 << $urandom_range(0, 31);
            2: v = $urandom();
            default: v = 32'hFFFF_FFFF;
         endcase
         send_beat(v, i == n - 1);
      end
   endtask

   // stimulus
   initial begin
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset groups (1..1), extremes of the value field
      send_beat(32'hFFFF_FFFF, 1'b1);
      send_beat(32'h0000_0000, 1'b1);
      send_beat(32'hAAAA_AAAA, 1'b0);
      send_beat(32'h5555_5555, 1'b1);
      // wide group range
      set_groups(1, 256);
      send_beat(32'h5555_5555, 1'b0);
      send_beat(32'hAAAA_AAAA, 1'b0);
      send_beat(32'h0000_0003, 1'b1);
      // min above max: infeasible
      set_groups(3, 2);
      send_sequence(4, 0);
      // min above the item count
      set_groups(5, 8);
      send_sequence(3, 2);
      // zero groups
      set_groups(0, 0);
      send_sequence(2, 0);
      // zero minimum, max of the register width
      set_groups(0, 511);
      send_sequence(3, 1);
      // overflowing sequence: the beats past the store are dropped
      set_groups(2, 3);
      for (int i = 0; i < MAX_N + 3; i++)
         send_beat($urandom_range(0, 7), i == MAX_N + 2, 1'b1);

      // random phases
      while (beats_sent < RAND_ITEMS) begin
         case ($urandom_range(0, 9))
            0: set_groups(1, 256);
            1: set_groups($urandom_range(0, 9), $urandom_range(0, 9));
            2: set_groups(256, 256);
            default: begin
               n = $urandom_range(1, 4);
               set_groups(n, n + $urandom_range(0, 5));
            end
         endcase
         rsp_steady = ($urandom_range(0, 3) == 0);
         repeat (20) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            send_sequence(n, $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
         end
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d beats in %0d searches over several group ranges,", beats_sent,
               searches);
      $display("including infeasible ranges and an overflowing sequence; %0d results.",
               sb.results_seen);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // run limit
   initial begin
      #400_000_000;
      $display("Timeout with %0d results still expected", sb.pending());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[min_or_partition_search_unit.f]
+incdir+rtl/core
rtl/core/mops_pkg.sv
rtl/core/mops_ram.sv
rtl/core/min_or_partition_search_unit.sv
rtl/core/mops_checker.sv
dv/tb_top.sv
